@@ rtl/dosux_pkg.sv @@
package dosux_pkg;

    // Stream widths: input data is dos_time, dos_date, unix_seconds (64 bits);
    // output data is unix_seconds_out, dos_time_out, dos_date_out padded to 72 bits.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Selector codes carried on the input tuser.
    localparam logic ACT_DOS_TO_UNIX = 1'b0;
    localparam logic ACT_UNIX_TO_DOS = 1'b1;

    // Calendar constants.
    localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
    localparam logic [15:0] DAYS_TO_1980      = 16'd3652;
    localparam logic [15:0] DAYS_TO_1980_LEAP = 16'd3653;
    localparam logic [31:0] SECS_AT_1980      = 32'd315532800;
    localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;

    // Reciprocals for the constant divisions. The quotient is taken from the
    // upper product bits: by day at bit 32 (may be one low), by hour at bit
    // 27, by minute at bit 23 and by year at bit 24 (all exact in range).
    localparam logic [15:0] RECIP_DAY  = 16'd49710;
    localparam logic [15:0] RECIP_HOUR = 16'd37283;
    localparam logic [17:0] RECIP_MIN  = 18'd139811;
    localparam logic [15:0] RECIP_YEAR = 16'd45965;

    // Day of year at which each month starts; codes above December read zero.
    localparam logic [8:0] MONTH_START [16] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212,
        9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0, 9'd0
    };

    // Per-stage load enables handed to the datapath blocks.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } dosux_load_t;

endpackage

@@ rtl/dosux_to_unix.sv @@
module dosux_to_unix
(
    input  logic                clk,
    input  dosux_pkg::dosux_load_t load,
    input  logic [15:0]         dos_time,
    input  logic [15:0]         dos_date,
    output logic [32:0]         unix_seconds
);

    logic [3:0]  mfield;
    logic [3:0]  mi;
    logic [6:0]  year;
    logic        leap_fix;
    logic [15:0] days_next;
    logic [16:0] hms_next;
    logic [32:0] secs_next;
    logic [15:0] days_reg;
    logic [16:0] hms_reg;
    logic [32:0] secs_reg [2:6];

    // Stage 1: day count and seconds within the day from the packed fields.
    always_comb
    begin
        mfield   = dos_date[8:5];
        mi       = (mfield == 4'd0) ? 4'd0 : mfield - 4'd1;
        year     = dos_date[15:9];
        leap_fix = (year[1:0] == 2'b00) && (mi < 4'd2);
        days_next = 16'(dos_date[4:0]) + 16'(dosux_pkg::MONTH_START[mi])
                  + 16'(year[6:2]) + 16'(year) * 16'(dosux_pkg::DAYS_PER_YEAR)
                  + dosux_pkg::DAYS_TO_1980_LEAP - 16'd1 - 16'(leap_fix);
        hms_next  = 17'({dos_time[4:0], 1'b0}) + 17'(dos_time[10:5]) * 17'd60
                  + 17'(dos_time[15:11]) * 17'(dosux_pkg::SECS_PER_HOUR);
    end

    // Stage 2: scale days to seconds.
    assign secs_next = 33'(days_reg) * 33'(dosux_pkg::SECS_PER_DAY) + 33'(hms_reg);

    // Stage registers, then a delay line that keeps the result in step with
    // the longer Unix to DOS path.
    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            days_reg <= days_next;
            hms_reg  <= hms_next;
        end
        if (load.s2)
        begin
            secs_reg[2] <= secs_next;
        end
        if (load.s3)
        begin
            secs_reg[3] <= secs_reg[2];
        end
        if (load.s4)
        begin
            secs_reg[4] <= secs_reg[3];
        end
        if (load.s5)
        begin
            secs_reg[5] <= secs_reg[4];
        end
        if (load.s6)
        begin
            secs_reg[6] <= secs_reg[5];
        end
    end

    assign unix_seconds = secs_reg[6];

endmodule

@@ rtl/dosux_day_split.sv @@
module dosux_day_split
(
    input  logic                clk,
    input  dosux_pkg::dosux_load_t load,
    input  logic [31:0]         unix_seconds,
    output logic [16:0]         tod,
    output logic [15:0]         day_1980,
    output logic                clamped
);

    logic        below;
    logic [31:0] sc_next;
    logic [47:0] q_prod;
    logic [32:0] day_prod;
    logic [31:0] diff;
    logic [17:0] rem;
    logic        over;
    logic [31:0] sc1_reg;
    logic [15:0] q1_reg;
    logic        cl1_reg;
    logic [31:0] sc2_reg;
    logic [31:0] prod2_reg;
    logic [15:0] q2_reg;
    logic        cl2_reg;
    logic [16:0] tod3_reg;
    logic [15:0] dz3_reg;
    logic        cl3_reg;

    // Stage 1: saturate to 1980 and estimate the day number (may be one low).
    always_comb
    begin
        below   = unix_seconds < dosux_pkg::SECS_AT_1980;
        sc_next = below ? dosux_pkg::SECS_AT_1980 : unix_seconds;
        q_prod  = 48'(sc_next) * 48'(dosux_pkg::RECIP_DAY);
    end

    // Stage 2: seconds at the start of the estimated day.
    assign day_prod = 33'(q1_reg) * 33'(dosux_pkg::SECS_PER_DAY);

    // Stage 3: remainder below two days; one correction step fixes the estimate.
    always_comb
    begin
        diff = sc2_reg - prod2_reg;
        rem  = diff[17:0];
        over = rem >= 18'(dosux_pkg::SECS_PER_DAY);
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            sc1_reg <= sc_next;
            q1_reg  <= q_prod[47:32];
            cl1_reg <= below;
        end
        if (load.s2)
        begin
            sc2_reg   <= sc1_reg;
            prod2_reg <= day_prod[31:0];
            q2_reg    <= q1_reg;
            cl2_reg   <= cl1_reg;
        end
        if (load.s3)
        begin
            tod3_reg <= over ? 17'(rem - 18'(dosux_pkg::SECS_PER_DAY)) : rem[16:0];
            dz3_reg  <= q2_reg + 16'(over) - dosux_pkg::DAYS_TO_1980;
            cl3_reg  <= cl2_reg;
        end
    end

    assign tod      = tod3_reg;
    assign day_1980 = dz3_reg;
    assign clamped  = cl3_reg;

endmodule

@@ rtl/dosux_to_dos.sv @@
module dosux_to_dos
(
    input  logic                clk,
    input  dosux_pkg::dosux_load_t load,
    input  logic [16:0]         tod,
    input  logic [15:0]         day_1980,
    input  logic                clamped_in,
    output logic [15:0]         dos_time,
    output logic [15:0]         dos_date,
    output logic                clamped
);

    logic [31:0] hour_prod;
    logic [33:0] min_prod;
    logic [30:0] year_prod;
    logic [16:0] sec_full;
    logic [10:0] minute_full;
    logic [15:0] base_a;
    logic [15:0] base_b;
    logic        late;
    logic        leap;
    logic        feb29;
    logic [8:0]  nl;
    logic [11:0] started;
    logic [3:0]  month_cnt;
    logic [3:0]  mprev;
    logic [4:0]  hour4_reg;
    logic [10:0] mt4_reg;
    logic [16:0] tod4_reg;
    logic [6:0]  y4_reg;
    logic [15:0] dz4_reg;
    logic        cl4_reg;
    logic [15:0] tw5_reg;
    logic [6:0]  year5_reg;
    logic [8:0]  doy5_reg;
    logic        cl5_reg;
    logic [15:0] tw6_reg;
    logic [6:0]  year6_reg;
    logic [8:0]  nl6_reg;
    logic [3:0]  month6_reg;
    logic        cl6_reg;

    // Stage 4: hours, total minutes and a year estimate by reciprocals.
    always_comb
    begin
        hour_prod = 32'(tod) * 32'(dosux_pkg::RECIP_HOUR);
        min_prod  = 34'(tod) * 34'(dosux_pkg::RECIP_MIN);
        year_prod = 31'(day_1980) * 31'(dosux_pkg::RECIP_YEAR);
    end

    // Stage 5: seconds and minute fields; step the year back when the leap
    // days push its start past the day number.
    always_comb
    begin
        sec_full    = tod4_reg - 17'(mt4_reg) * 17'd60;
        minute_full = mt4_reg - 11'(hour4_reg) * 11'd60;
        base_a = 16'((8'(y4_reg) + 8'd3) >> 2)
               + 16'(y4_reg) * 16'(dosux_pkg::DAYS_PER_YEAR);
        base_b = 16'((8'(y4_reg) + 8'd2) >> 2)
               + 16'(y4_reg - 7'd1) * 16'(dosux_pkg::DAYS_PER_YEAR);
        late   = base_a > dz4_reg;
    end

    // Stage 6: place February 29 and find the month by table compare.
    always_comb
    begin
        leap  = year5_reg[1:0] == 2'b00;
        feb29 = leap && (doy5_reg == 9'd59);
        nl    = (!leap || doy5_reg <= 9'd59) ? doy5_reg : doy5_reg - 9'd1;
        for (int m = 0; m < 12; m++)
        begin
            started[m] = nl >= dosux_pkg::MONTH_START[m];
        end
        month_cnt = 4'd0;
        for (int m = 0; m < 12; m++)
        begin
            month_cnt = month_cnt + 4'(started[m]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            hour4_reg <= hour_prod[31:27];
            mt4_reg   <= min_prod[33:23];
            tod4_reg  <= tod;
            y4_reg    <= year_prod[30:24];
            dz4_reg   <= day_1980;
            cl4_reg   <= clamped_in;
        end
        if (load.s5)
        begin
            tw5_reg   <= {hour4_reg, minute_full[5:0], sec_full[5:1]};
            year5_reg <= late ? y4_reg - 7'd1 : y4_reg;
            doy5_reg  <= 9'(dz4_reg - (late ? base_b : base_a));
            cl5_reg   <= cl4_reg;
        end
        if (load.s6)
        begin
            tw6_reg    <= tw5_reg;
            year6_reg  <= year5_reg;
            nl6_reg    <= nl;
            month6_reg <= feb29 ? 4'd2 : month_cnt;
            cl6_reg    <= cl5_reg;
        end
    end

    // Date word from day within month, month and year.
    assign mprev    = month6_reg - 4'd1;
    assign dos_date = 16'(nl6_reg) - 16'(dosux_pkg::MONTH_START[mprev]) + 16'd1
                    + (16'(month6_reg) << 5) + (16'(year6_reg) << 9);
    assign dos_time = tw6_reg;
    assign clamped  = cl6_reg;

endmodule

@@ rtl/dos_unix_timestamp_convert.sv @@
// Throughput: one item per cycle while m_tready is high; each of the eight
// register stages holds only short arithmetic with constant multipliers, and
// the stages advance independently so bubbles close up while the output is stalled.
// Reset: all stage valid bits clear, the pipeline is empty and ready at once.
module dos_unix_timestamp_convert
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // dos_time [15:0], dos_date [31:16], unix_seconds [63:32]
    input  logic [dosux_pkg::S_TDATA_W-1:0] s_tdata,
    // action [0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // unix_seconds_out [32:0], dos_time_out [48:33], dos_date_out [64:49], zero above
    output logic [dosux_pkg::M_TDATA_W-1:0] m_tdata,
    // clamped [0]
    output logic [0:0]                      m_tuser
);

    logic [7:0]  valid_reg;
    logic [7:0]  rdy;
    logic [6:0]  act_reg;
    logic [15:0] time_reg;
    logic [15:0] date_reg;
    logic [31:0] secs_reg;
    logic [32:0] unix_out_reg;
    logic [15:0] tw_out_reg;
    logic [15:0] dw_out_reg;
    logic        cl_out_reg;
    logic        act_out_reg;

    dosux_pkg::dosux_load_t load;
    logic [32:0] unix_res;
    logic [16:0] tod;
    logic [15:0] day_1980;
    logic        clamped_split;
    logic [15:0] dos_time_res;
    logic [15:0] dos_date_res;
    logic        clamped_res;

    // Each stage takes a new item when it is empty or its successor moves on.
    always_comb
    begin
        rdy[7] = !valid_reg[7] || m_tready;
        for (int i = 6; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
    end

    assign load.s1 = rdy[1];
    assign load.s2 = rdy[2];
    assign load.s3 = rdy[3];
    assign load.s4 = rdy[4];
    assign load.s5 = rdy[5];
    assign load.s6 = rdy[6];

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[7];
    assign m_tdata  = {7'd0, dw_out_reg, tw_out_reg, unix_out_reg};
    assign m_tuser  = cl_out_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < 8; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // Input register and the action bit that follows each item.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            act_reg[0] <= s_tuser[0];
            time_reg   <= s_tdata[15:0];
            date_reg   <= s_tdata[31:16];
            secs_reg   <= s_tdata[63:32];
        end
        for (int i = 1; i < 7; i++)
        begin
            if (rdy[i])
            begin
                act_reg[i] <= act_reg[i - 1];
            end
        end
    end

    dosux_to_unix u_to_unix
    (
        .clk          (clk),
        .load         (load),
        .dos_time     (time_reg),
        .dos_date     (date_reg),
        .unix_seconds (unix_res)
    );

    dosux_day_split u_day_split
    (
        .clk          (clk),
        .load         (load),
        .unix_seconds (secs_reg),
        .tod          (tod),
        .day_1980     (day_1980),
        .clamped      (clamped_split)
    );

    dosux_to_dos u_to_dos
    (
        .clk        (clk),
        .load       (load),
        .tod        (tod),
        .day_1980   (day_1980),
        .clamped_in (clamped_split),
        .dos_time   (dos_time_res),
        .dos_date   (dos_date_res),
        .clamped    (clamped_res)
    );

    // Result register: the unused direction's fields read zero.
    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            act_out_reg <= act_reg[6];
            if (act_reg[6] == dosux_pkg::ACT_UNIX_TO_DOS)
            begin
                unix_out_reg <= '0;
                tw_out_reg   <= dos_time_res;
                dw_out_reg   <= dos_date_res;
                cl_out_reg   <= clamped_res;
            end
            else
            begin
                unix_out_reg <= unix_res;
                tw_out_reg   <= '0;
                dw_out_reg   <= '0;
                cl_out_reg   <= 1'b0;
            end
        end
    end

    // The input only stalls when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    a_to_unix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (act_out_reg == dosux_pkg::ACT_DOS_TO_UNIX)
        |-> (tw_out_reg == 16'd0) && (dw_out_reg == 16'd0) && !cl_out_reg)
        else $error("DOS fields set on a DOS to Unix item");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (act_out_reg == dosux_pkg::ACT_UNIX_TO_DOS)
        |-> (unix_out_reg == 33'd0) && (tw_out_reg[15:11] <= 5'd23)
            && (tw_out_reg[10:5] <= 6'd59) && (tw_out_reg[4:0] <= 5'd29))
        else $error("time word out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (act_out_reg == dosux_pkg::ACT_UNIX_TO_DOS)
        |-> (dw_out_reg[8:5] >= 4'd1) && (dw_out_reg[8:5] <= 4'd12)
            && (dw_out_reg[4:0] >= 5'd1))
        else $error("date word out of range");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cl_out_reg |-> (tw_out_reg == 16'd0) && (dw_out_reg == 16'h0021))
        else $error("saturated item is not 1980-01-01");

endmodule
